FILE: rtl/core/mld_pkg.sv
// Shared types, constants and the 1-3-3-1 tap function of the mipmap level downsampler.
// No dependencies; every other file of the block imports this package.
package mld_pkg;

   // Sizes
   localparam int MAX_IN_WIDTH_DEF = 4096;
   localparam int MAX_IN_HEIGHT    = 4096;
   localparam int HW               = 13;    // height register width
   localparam int RW               = 12;    // row position width
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 13;
   localparam int SUM_W            = 11;    // one horizontal sum, at most 8*255
   localparam int ACC_W            = 14;    // vertical sum, at most 64*255
   localparam int FRAC_BITS        = 6;     // weights sum to 64
   localparam int NUM_LINES        = 3;
   localparam int NUM_TAPS         = 4;
   localparam int OUT_POS_W        = 11;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_WIDTH  = 1'b0,
      CSR_IN_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_data_type;

   typedef struct packed {
      logic [7:0]           out_red;
      logic [7:0]           out_green;
      logic [7:0]           out_blue;
      logic [OUT_POS_W-1:0] out_col;
      logic [OUT_POS_W-1:0] out_row;
      logic                 last_pixel;
   } rsp_data_type;

   // One entry of a line of horizontal sums
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } hsum_type;

   // Tap distance back from the current position: 0 is the current one
   typedef logic [1:0] tap_sel_type;
   localparam tap_sel_type TAP_CUR = 2'd0;

   typedef logic [1:0] line_type;
   localparam line_type LAST_LINE = line_type'(NUM_LINES - 1);

   // Transaction passed from the front end to the vertical stage
   typedef struct packed {
      hsum_type                        hs;
      tap_sel_type [NUM_TAPS-1:0]      vsel;
      line_type                        line_cur;
      logic [OUT_POS_W-1:0]            col;
      logic [OUT_POS_W-1:0]            row;
      logic                            last;
   } front_out_type;

   // a + 3b + 3c + d
   function automatic logic [ACC_W-1:0] tap_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b,
                                                 input logic [SUM_W-1:0] c,
                                                 input logic [SUM_W-1:0] d);
      return ACC_W'(a) + ACC_W'(d)
           + (ACC_W'(b) << 1) + ACC_W'(b)
           + (ACC_W'(c) << 1) + ACC_W'(c);
   endfunction

endpackage

FILE: rtl/core/mld_line_store.sv
// Three lines of horizontal sums, one synchronous memory per line.
// Depends on mld_pkg. Read data is registered; a same-cycle write returns the old entry.
module mld_line_store #(
   parameter int  MAX_IN_WIDTH = mld_pkg::MAX_IN_WIDTH_DEF,
   localparam int HALF         = MAX_IN_WIDTH / 2,
   localparam int AW           = (HALF > 1) ? $clog2(HALF) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  mld_pkg::line_type  wr_line,
   input  mld_pkg::hsum_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      addr,
   output mld_pkg::hsum_type  rd_data [mld_pkg::NUM_LINES]
);
   import mld_pkg::*;

   for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
      hsum_type mem [HALF];
      hsum_type rd_ff;

      // read-first: the old entry is what the vertical filter wants
      always_ff @(posedge clock) begin
         if (wr_en && (wr_line == line_type'(i))) begin
            mem[addr] <= wr_data;
         end
         if (rd_en) begin
            rd_ff <= mem[addr];
         end
      end

      assign rd_data[i] = rd_ff;
   end

endmodule

FILE: rtl/core/mld_front.sv
// Position tracking, pixel history, horizontal 1-3-3-1 filter and vertical tap selection.
// Depends on mld_pkg. Feeds the line store and the vertical stage.
module mld_front #(
   parameter int  MAX_IN_WIDTH = mld_pkg::MAX_IN_WIDTH_DEF,
   localparam int CW           = $clog2(MAX_IN_WIDTH),
   localparam int WW           = $clog2(MAX_IN_WIDTH + 1),
   localparam int HALF         = MAX_IN_WIDTH / 2,
   localparam int AW           = (HALF > 1) ? $clog2(HALF) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   accept,
   input  mld_pkg::req_data_type  req_data,
   input  logic [WW-1:0]          width,
   input  logic [mld_pkg::HW-1:0] height,
   output logic                   hx_valid,
   output logic                   produce,
   output logic [AW-1:0]          mem_addr,
   output mld_pkg::front_out_type front_out
);
   import mld_pkg::*;

   localparam int HJW = CW + 2;
   localparam int VJW = RW + 2;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   line_type      line_ff, line_in;
   req_data_type  rp_ff [3];
   req_data_type  rp_in [3];

   logic [WW-1:0] w_m1, ow;
   logic [CW-1:0] col_half, ox;
   logic          col_at_end, col_even_hit;
   logic [HW-1:0] h_m1, oh;
   logic [RW-1:0] row_half, oy;
   logic          row_at_end, row_even_hit, vy_valid;

   logic [HJW-1:0] hj_raw [NUM_TAPS];
   logic [HJW-1:0] hj     [NUM_TAPS];
   logic [HJW-1:0] hdiff  [NUM_TAPS];
   logic [VJW-1:0] vj_raw [NUM_TAPS];
   logic [VJW-1:0] vj     [NUM_TAPS];
   logic [VJW-1:0] vdiff  [NUM_TAPS];
   req_data_type   px     [NUM_TAPS];
   hsum_type       hs;

   // Which output column / row the current position completes
   always_comb begin
      w_m1         = width - WW'(1);
      ow           = width >> 1;
      if (ow == '0) begin
         ow = WW'(1);
      end
      col_half     = col_ff >> 1;
      col_at_end   = (WW'(col_ff) == w_m1);
      col_even_hit = !col_ff[0] && (col_half != '0) && (WW'(col_half) < ow);
      hx_valid     = col_at_end || col_even_hit;
      ox           = col_at_end ? CW'(ow - WW'(1)) : col_half - CW'(1);

      h_m1         = height - HW'(1);
      oh           = height >> 1;
      if (oh == '0) begin
         oh = HW'(1);
      end
      row_half     = row_ff >> 1;
      row_at_end   = (HW'(row_ff) == h_m1);
      row_even_hit = !row_ff[0] && (row_half != '0) && (HW'(row_half) < oh);
      vy_valid     = row_at_end || row_even_hit;
      oy           = row_at_end ? RW'(oh - HW'(1)) : row_half - RW'(1);

      produce      = hx_valid && vy_valid;
      mem_addr     = AW'(ox);
   end

   // Clamped tap positions, turned into distances back from the current position
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         hj_raw[k] = {1'b0, ox, 1'b0} + HJW'(k);
         hj[k]     = (hj_raw[k] == '0) ? '0 : hj_raw[k] - HJW'(1);
         if (hj[k] > HJW'(w_m1)) begin
            hj[k] = HJW'(w_m1);
         end
         hdiff[k]  = HJW'(col_ff) - hj[k];

         vj_raw[k] = {1'b0, oy, 1'b0} + VJW'(k);
         vj[k]     = (vj_raw[k] == '0) ? '0 : vj_raw[k] - VJW'(1);
         if (vj[k] > VJW'(h_m1)) begin
            vj[k] = VJW'(h_m1);
         end
         vdiff[k]  = VJW'(row_ff) - vj[k];

         case (tap_sel_type'(hdiff[k][1:0]))
            TAP_CUR: px[k] = req_data;
            2'd1:    px[k] = rp_ff[0];
            2'd2:    px[k] = rp_ff[1];
            default: px[k] = rp_ff[2];
         endcase
      end
   end

   // Horizontal filter
   always_comb begin
      hs.red   = SUM_W'(tap_sum(SUM_W'(px[0].in_red),   SUM_W'(px[1].in_red),
                                SUM_W'(px[2].in_red),   SUM_W'(px[3].in_red)));
      hs.green = SUM_W'(tap_sum(SUM_W'(px[0].in_green), SUM_W'(px[1].in_green),
                                SUM_W'(px[2].in_green), SUM_W'(px[3].in_green)));
      hs.blue  = SUM_W'(tap_sum(SUM_W'(px[0].in_blue),  SUM_W'(px[1].in_blue),
                                SUM_W'(px[2].in_blue),  SUM_W'(px[3].in_blue)));
   end

   always_comb begin
      front_out.hs       = hs;
      for (int k = 0; k < NUM_TAPS; k++) begin
         front_out.vsel[k] = tap_sel_type'(vdiff[k][1:0]);
      end
      front_out.line_cur = line_ff;
      front_out.col      = OUT_POS_W'(ox);
      front_out.row      = OUT_POS_W'(oy);
      front_out.last     = (ox == CW'(ow - WW'(1))) && (oy == RW'(oh - HW'(1)));
   end

   // Position, line and history update
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      line_in = line_ff;
      rp_in   = rp_ff;
      if (accept) begin
         rp_in[2] = rp_ff[1];
         rp_in[1] = rp_ff[0];
         rp_in[0] = req_data;
      end
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         line_in = '0;
      end else if (accept) begin
         if (col_at_end) begin
            col_in = '0;
            if (row_at_end) begin
               row_in  = '0;
               line_in = '0;
            end else begin
               row_in  = row_ff + RW'(1);
               line_in = (line_ff == LAST_LINE) ? '0 : line_ff + line_type'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         line_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            rp_ff[i] <= '0;
         end
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         line_ff <= line_in;
         rp_ff   <= rp_in;
      end
   end

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < width)
      else $error("column position beyond the frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      HW'(row_ff) < height)
      else $error("row position beyond the frame height");

   a_line_tracks_row: assert property (@(posedge clock) disable iff (reset)
      (row_ff == '0) |-> (line_ff == '0))
      else $error("line index out of step with the row position");

endmodule

FILE: rtl/core/mld_back.sv
// Vertical 1-3-3-1 filter over line store data and output register.
// Depends on mld_pkg. Holds one transaction while the output register is full and stalled.
module mld_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  mld_pkg::front_out_type front_out,
   input  mld_pkg::hsum_type      rd_data [mld_pkg::NUM_LINES],
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output mld_pkg::rsp_data_type  rsp_data,
   output logic                   hold
);
   import mld_pkg::*;

   front_out_type s1_ff, s1_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   logic          adv, s1_move;
   hsum_type      row_val [NUM_TAPS];
   hsum_type      tv      [NUM_TAPS];
   logic [ACC_W-1:0] acc_red, acc_green, acc_blue;

   assign adv     = !rsp_valid_ff || !rsp_stall;
   assign s1_move = s1_valid_ff && adv;
   assign hold    = s1_valid_ff && !adv;

   // Rows r-1 and r-2 live in the lines before the current one; row r-3 is the old entry of the current line
   always_comb begin
      row_val[0] = s1_ff.hs;
      case (s1_ff.line_cur)
         2'd1: begin
            row_val[1] = rd_data[0];
            row_val[2] = rd_data[2];
            row_val[3] = rd_data[1];
         end
         2'd2: begin
            row_val[1] = rd_data[1];
            row_val[2] = rd_data[0];
            row_val[3] = rd_data[2];
         end
         default: begin
            row_val[1] = rd_data[2];
            row_val[2] = rd_data[1];
            row_val[3] = rd_data[0];
         end
      endcase
      for (int k = 0; k < NUM_TAPS; k++) begin
         tv[k] = row_val[s1_ff.vsel[k]];
      end
   end

   // Vertical filter, divide by 64
   always_comb begin
      acc_red   = tap_sum(tv[0].red,   tv[1].red,   tv[2].red,   tv[3].red);
      acc_green = tap_sum(tv[0].green, tv[1].green, tv[2].green, tv[3].green);
      acc_blue  = tap_sum(tv[0].blue,  tv[1].blue,  tv[2].blue,  tv[3].blue);
   end

   // Stage and output register control
   always_comb begin
      s1_in        = s1_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         s1_in       = front_out;
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_red    = acc_red[ACC_W-1:FRAC_BITS];
         rsp_data_in.out_green  = acc_green[ACC_W-1:FRAC_BITS];
         rsp_data_in.out_blue   = acc_blue[ACC_W-1:FRAC_BITS];
         rsp_data_in.out_col    = s1_ff.col;
         rsp_data_in.out_row    = s1_ff.row;
         rsp_data_in.last_pixel = s1_ff.last;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff       <= s1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      hold |-> !load)
      else $error("held transaction overwritten");

   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      hold |=> s1_valid_ff && $stable(s1_ff))
      else $error("held transaction lost or changed");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result raised without a pending transaction");

endmodule

FILE: rtl/core/mipmap_level_downsampler.sv
// Mipmap level downsampler: 2x reduction with a separable 1-3-3-1 filter, clamped edges.
// The completing input transaction is registered in the filter stage, then in the rsp register that drives rsp_valid.
// Throughput: one input pixel per cycle while req_stall is low; the line store is read and written in the same cycle.
// req_stall is high while the filter stage holds a transaction behind a stalled rsp register.
// Reset clears positions, pixel history and pipeline valids; width and height return to 1.
// The line store is not cleared: every entry is written within a frame before it is read.
// Depends on mld_pkg, mld_front, mld_line_store, mld_back.
module mipmap_level_downsampler #(
   parameter int  MAX_IN_WIDTH = mld_pkg::MAX_IN_WIDTH_DEF,
   localparam int WW           = $clog2(MAX_IN_WIDTH + 1),
   localparam int HALF         = MAX_IN_WIDTH / 2,
   localparam int AW           = (HALF > 1) ? $clog2(HALF) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mld_pkg::req_data_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mld_pkg::rsp_data_type          rsp_data,
   input  logic                           csr_we,
   input  logic [mld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mld_pkg::*;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   logic          accept, hold, hx_valid, produce;
   logic [AW-1:0] mem_addr;
   front_out_type front_out;
   hsum_type      rd_data [NUM_LINES];

   assign req_stall = hold;
   assign accept    = req_valid && !req_stall;

   // Configuration registers hold the effective (range-limited) sizes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IN_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_in = WW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_IN_WIDTH)) begin
                  width_in = WW'(MAX_IN_WIDTH);
               end else begin
                  width_in = WW'(csr_wdata);
               end
            end
            CSR_IN_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_in = HW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_IN_HEIGHT)) begin
                  height_in = HW'(MAX_IN_HEIGHT);
               end else begin
                  height_in = HW'(csr_wdata);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(1);
         height_ff <= HW'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   mld_front #(
      .MAX_IN_WIDTH (MAX_IN_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_we),
      .accept    (accept),
      .req_data  (req_data),
      .width     (width_ff),
      .height    (height_ff),
      .hx_valid  (hx_valid),
      .produce   (produce),
      .mem_addr  (mem_addr),
      .front_out (front_out)
   );

   mld_line_store #(
      .MAX_IN_WIDTH (MAX_IN_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && hx_valid),
      .wr_line (front_out.line_cur),
      .wr_data (front_out.hs),
      .rd_en   (accept && produce),
      .addr    (mem_addr),
      .rd_data (rd_data)
   );

   mld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && produce),
      .front_out (front_out),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .hold      (hold)
   );

endmodule
